### src/ssfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfm_pkg
// Shared types, constants and helpers for the streaming first-match search.
// ----------------------------------------------------------------------------
package ssfm_pkg;

   // longest key and derived widths
   localparam int KEY_MAX   = 8;
   localparam int CHAR_W    = 8;
   localparam int KEY_W     = 64;
   localparam int LEN_W     = 4;
   localparam int COUNT_W   = 16;
   localparam int KEY_IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

   // configuration bus
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam logic [COUNT_W-1:0] NOT_FOUND_POS = 16'hffff;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hffff;

   // register indexes (byte address / 8)
   typedef enum logic [0:0] {
      REG_KEY_BYTES  = 1'b0,
      REG_KEY_LENGTH = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] position;
   } rsp_type;

   // control broadcast to every window cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // clamp the programmed length into 1..KEY_MAX
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] len;
      len = raw;
      if (len == '0) begin
         len = LEN_W'(1);
      end
      if (len > LEN_W'(KEY_MAX)) begin
         len = LEN_W'(KEY_MAX);
      end
      return len;
   endfunction

   // key character that a window character of the given age must equal
   function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] key,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [LEN_W-1:0] age);
      logic [LEN_W-1:0]     diff;
      logic [KEY_IDX_W-1:0] idx;
      diff = len - LEN_W'(1) - age;
      idx  = diff[KEY_IDX_W-1:0];
      return key[idx*CHAR_W +: CHAR_W];
   endfunction

endpackage
`default_nettype wire

### src/ssfm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfm_cell
// One window position: holds a character and its valid bit, passes them on
// to the next cell on every beat and compares against its key character.
// ----------------------------------------------------------------------------
module ssfm_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  ssfm_pkg::cell_ctrl_type       ctrl,
   input  wire [ssfm_pkg::LEN_W-1:0]     age_num,
   input  wire [ssfm_pkg::KEY_W-1:0]     key_bytes,
   input  wire [ssfm_pkg::LEN_W-1:0]     key_len,
   input  wire [ssfm_pkg::CHAR_W-1:0]    char_prev,
   input  wire                           valid_prev,
   output logic [ssfm_pkg::CHAR_W-1:0]   char_ff,
   output logic                          valid_ff,
   output logic                          hit
);
   import ssfm_pkg::*;

   logic [CHAR_W-1:0] char_in;
   logic              valid_in;

   // shift from the neighbour; drop the valid bit at end of string
   always_comb begin
      char_in  = char_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         char_in  = char_prev;
         valid_in = valid_prev;
      end
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   // age is the position this character takes once the new beat shifts in
   assign hit = (age_num >= key_len) ||
                (valid_ff && (char_ff == key_char(key_bytes, key_len, age_num)));

endmodule
`default_nettype wire

### src/ssfm_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfm_csr
// Register file for the key and its length on an APB-style port.
// ----------------------------------------------------------------------------
module ssfm_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [ssfm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [ssfm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ssfm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [ssfm_pkg::KEY_W-1:0]       key_bytes,
   output logic [ssfm_pkg::LEN_W-1:0]       key_len
);
   import ssfm_pkg::*;

   logic [KEY_W-1:0] key_bytes_ff;
   logic [KEY_W-1:0] key_bytes_in;
   logic [LEN_W-1:0] key_length_ff;
   logic [LEN_W-1:0] key_length_in;
   logic             wr_en;
   reg_index_type    reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[3]);

   // decode the write
   always_comb begin
      key_bytes_in  = key_bytes_ff;
      key_length_in = key_length_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_KEY_BYTES: begin
               key_bytes_in = csr_pwdata[KEY_W-1:0];
            end
            REG_KEY_LENGTH: begin
               key_length_in = csr_pwdata[LEN_W-1:0];
            end
            default: begin
               key_bytes_in = key_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff  <= '0;
         key_length_ff <= LEN_W'(1);
      end else begin
         key_bytes_ff  <= key_bytes_in;
         key_length_ff <= key_length_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         REG_KEY_BYTES:  csr_prdata = CSR_DATA_W'(key_bytes_ff);
         REG_KEY_LENGTH: csr_prdata = CSR_DATA_W'(key_length_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign key_bytes = key_bytes_ff;
   assign key_len   = eff_len(key_length_ff);

endmodule
`default_nettype wire

### src/stream_substring_first_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stream_substring_first_match
// Streaming search for the first occurrence of a 1 to 8 character key.
// ----------------------------------------------------------------------------
// Feed the subject one character per beat with is_last on the final one. The
// block takes one character every clock cycle: the window is a chain of cells
// that shift and compare in the same cycle, and a single output register holds
// the result, so input is stalled only while that register is full and the
// result side stalls. For each string exactly one result comes out in the cycle
// after the beat that decides it: found=1 with the zero-based start of the
// first match, or found=0 with position 0xffff after the final character. All
// per-string state clears after the final character. Program key_bytes (first
// character in the lowest byte, address 0) and key_length (address 8) only
// while no string is in progress; a length of 0 acts as 1 and above 8 as 8.
// ----------------------------------------------------------------------------
module stream_substring_first_match (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  ssfm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output ssfm_pkg::rsp_type                rsp_data,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [ssfm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [ssfm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ssfm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import ssfm_pkg::*;

   logic [KEY_W-1:0]   key_bytes;
   logic [LEN_W-1:0]   key_len;
   logic               req_take;
   logic               rsp_take;
   cell_ctrl_type      ctrl;

   logic [CHAR_W-1:0]  cell_char [KEY_MAX];
   logic               cell_valid [KEY_MAX];
   logic [KEY_MAX-1:0] cell_hit;
   logic               head_hit;
   logic               match;

   logic [COUNT_W-1:0] char_count_ff;
   logic [COUNT_W-1:0] char_count_in;
   logic               matched_ff;
   logic               matched_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   logic               emit_found;
   logic               emit_miss;

   ssfm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_bytes   (key_bytes),
      .key_len     (key_len)
   );

   // handshake: stall only while a result waits and cannot leave
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign ctrl.shift = req_take;
   assign ctrl.clear = req_take && req_data.is_last;

   // window chain: cell k holds the character that becomes age k+1
   for (genvar k = 0; k < KEY_MAX; k++) begin : g_cell
      ssfm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .age_num    (LEN_W'(k + 1)),
         .key_bytes  (key_bytes),
         .key_len    (key_len),
         .char_prev  ((k == 0) ? req_data.char_in : cell_char[(k == 0) ? 0 : k - 1]),
         .valid_prev ((k == 0) ? 1'b1 : cell_valid[(k == 0) ? 0 : k - 1]),
         .char_ff    (cell_char[k]),
         .valid_ff   (cell_valid[k]),
         .hit        (cell_hit[k])
      );
   end

   // newest character compares against the last key character
   assign head_hit = (req_data.char_in == key_char(key_bytes, key_len, '0));
   assign match    = head_hit && (&cell_hit);

   assign emit_found = req_take && !matched_ff && match;
   assign emit_miss  = req_take && !matched_ff && !match && req_data.is_last;

   // advance the string state
   always_comb begin
      char_count_in = char_count_ff;
      matched_in    = matched_ff;
      if (req_take) begin
         if (char_count_ff != COUNT_MAX) begin
            char_count_in = char_count_ff + COUNT_W'(1);
         end
         if (emit_found) begin
            matched_in = 1'b1;
         end
         if (req_data.is_last) begin
            char_count_in = '0;
            matched_in    = 1'b0;
         end
      end
   end

   // load the output register, or drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_found) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.found    = 1'b1;
         rsp_data_in.position = char_count_ff - (COUNT_W'(key_len) - COUNT_W'(1));
      end else if (emit_miss) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.found    = 1'b0;
         rsp_data_in.position = NOT_FOUND_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         matched_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         char_count_ff <= char_count_in;
         matched_ff    <= matched_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
